@@ rtl/psi_pkg.sv @@
// Shared constants, codes and types for the priority scheduler with inheritance.
package psi_pkg;

  localparam int NUM_TASKS = 8;
  localparam int PRIO_BITS = 4;
  localparam int TIME_BITS = 32;
  localparam int TASK_BITS = $clog2(NUM_TASKS);

  typedef logic [PRIO_BITS-1:0] prio_t;
  typedef logic [TASK_BITS-1:0] task_idx_t;
  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [NUM_TASKS-1:0] task_mask_t;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_RELEASE = 3'd1;
  localparam logic [2:0] CMD_LOCK    = 3'd2;
  localparam logic [2:0] CMD_UNLOCK  = 3'd3;
  localparam logic [2:0] CMD_END     = 3'd4;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NO_RUNNING = 2'd1;
  localparam logic [1:0] STATUS_RULE       = 2'd2;
  localparam logic [1:0] STATUS_ACTIVE     = 2'd3;

  // One write into the task priority table.
  typedef struct packed {
    logic      we_base;
    logic      we_eff;
    task_idx_t idx;
    prio_t     base;
    prio_t     eff;
  } tbl_wr_t;

  // Operands of the shared priority comparator.
  typedef struct packed {
    logic  cand_v;
    prio_t cand_prio;
    logic  best_v;
    prio_t best_prio;
  } cmp_req_t;

endpackage

@@ rtl/psi_cmp.sv @@
// Shared priority comparator: decides whether a candidate beats the current best.
module psi_cmp (
  input  psi_pkg::cmp_req_t req,
  output logic              take
);
  import psi_pkg::*;

  // Strictly greater keeps the lowest index on ties when tasks are swept upwards.
  assign take = req.cand_v && (!req.best_v || (req.cand_prio > req.best_prio));

endmodule

@@ rtl/psi_task_tbl.sv @@
// Per-task base and effective priority table with one read and one write port.
module psi_task_tbl (
  input  logic                clk,
  input  logic                rst_n,
  input  psi_pkg::task_idx_t  rd_idx,
  output psi_pkg::prio_t      rd_base,
  output psi_pkg::prio_t      rd_eff,
  input  psi_pkg::tbl_wr_t    wr
);
  import psi_pkg::*;

  prio_t base_r [NUM_TASKS];
  prio_t eff_r  [NUM_TASKS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        base_r[i] <= '0;
        eff_r[i]  <= '0;
      end
    end else begin
      if (wr.we_base) begin
        base_r[wr.idx] <= wr.base;
      end
      if (wr.we_eff) begin
        eff_r[wr.idx] <= wr.eff;
      end
    end
  end

  assign rd_base = base_r[rd_idx];
  assign rd_eff  = eff_r[rd_idx];

endmodule

@@ rtl/priority_scheduler_with_inheritance.sv @@
// Top level of the preemptive fixed-priority scheduler with one mutex and priority inheritance.
// Steps: tick, release and unknown commands run EXEC and the POST sweep; lock, end and a refused
//   unlock run the PRE sweep, EXEC and POST, plus INHERIT for a lock that blocks with inheritance
//   on; unlock runs PRE, EXEC, RESTORE, the WAITER sweep and POST, plus the NEXT sweep and RAISE
//   for a handover under inheritance. One request at a time: in_stall stays high from acceptance
//   until the result enters the output register; each sweep presents one task a cycle.
// Reset (synchronous, active low) clears time, masks, priorities, mutex and inheritance enable.
module priority_scheduler_with_inheritance (
  input  logic                clk,
  input  logic                rst_n,
  // Configuration: inheritance enable.
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  // Request channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_command,
  input  logic [2:0]          in_task_id,
  input  logic [3:0]          in_base_priority,
  // Result channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_running_valid,
  output logic [2:0]          out_running_task,
  output logic [3:0]          out_running_priority,
  output logic                out_grant_valid,
  output logic [2:0]          out_granted_task,
  output logic [31:0]         out_wait_time,
  output logic [1:0]          out_status
);
  import psi_pkg::*;

  // The sequencer walks through a request step by step. Every priority maximum is found by
  // SCAN, which presents one task per cycle to the shared comparator; the purpose register
  // says which mask is swept and where control goes once the last task has been seen.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_INHERIT,
    ST_RESTORE,
    ST_RAISE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SP_PRE,     // running task before the command acts
    SP_WAITER,  // best waiter to hand the mutex to
    SP_NEXT,    // best waiter left after a handover
    SP_POST     // running task reported in the result
  } scan_purpose_t;

  localparam task_idx_t LAST_IDX = TASK_BITS'(NUM_TASKS - 1);

  state_t        state_r, state_nxt;
  scan_purpose_t purpose_r, purpose_nxt;
  task_idx_t     scan_idx_r, scan_idx_nxt;
  logic          best_v_r, best_v_nxt;
  task_idx_t     best_idx_r, best_idx_nxt;
  prio_t         best_prio_r, best_prio_nxt;
  prio_t         w_prio_r, w_prio_nxt;

  logic          inh_en_r, inh_en_nxt;
  task_mask_t    active_r, active_nxt;
  task_mask_t    blocked_r, blocked_nxt;
  logic          held_r, held_nxt;
  task_idx_t     owner_r, owner_nxt;
  time_t         time_r, time_nxt;

  logic [2:0]    cmd_r, cmd_nxt;
  logic [2:0]    tid_r, tid_nxt;
  prio_t         prio_r, prio_nxt;

  logic          status_ok_unused;
  logic [1:0]    status_r, status_nxt;
  logic          grant_v_r, grant_v_nxt;
  task_idx_t     grant_task_r, grant_task_nxt;
  time_t         wait_r, wait_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          o_run_v_r, o_run_v_nxt;
  logic [2:0]    o_run_task_r, o_run_task_nxt;
  logic [3:0]    o_run_prio_r, o_run_prio_nxt;
  logic          o_grant_v_r, o_grant_v_nxt;
  logic [2:0]    o_grant_task_r, o_grant_task_nxt;
  logic [31:0]   o_wait_r, o_wait_nxt;
  logic [1:0]    o_status_r, o_status_nxt;

  // Lock request time of each task; only a waiter's entry is ever read.
  time_t         req_time_r [NUM_TASKS];
  logic          rt_we;
  task_idx_t     rt_idx;

  task_idx_t     rd_idx;
  prio_t         rd_base;
  prio_t         rd_eff;
  tbl_wr_t       tbl_wr;
  cmp_req_t      cmp_req;
  logic          take;

  logic          scan_start;
  scan_purpose_t scan_sel;
  logic          scan_cand_v;
  logic          cur_v;
  task_idx_t     cur_idx;
  prio_t         cur_prio;
  logic          out_free;
  logic          tid_bad;

  assign status_ok_unused = 1'b0;

  psi_task_tbl u_tbl (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (rd_idx),
    .rd_base (rd_base),
    .rd_eff  (rd_eff),
    .wr      (tbl_wr)
  );

  psi_cmp u_cmp (
    .req  (cmp_req),
    .take (take)
  );

  // The table's read port follows the step: the swept task, the owner or the running task.
  always_comb begin
    unique case (state_r)
      ST_INHERIT: rd_idx = owner_r;
      ST_RESTORE: rd_idx = best_idx_r;
      default:    rd_idx = scan_idx_r;
    endcase
  end

  // Sweeps over the runnable set or over the waiters, depending on the scan purpose.
  always_comb begin
    if ((purpose_r == SP_WAITER) || (purpose_r == SP_NEXT)) begin
      scan_cand_v = blocked_r[scan_idx_r];
    end else begin
      scan_cand_v = active_r[scan_idx_r] & ~blocked_r[scan_idx_r];
    end
  end

  // Operand selection for the one comparator.
  always_comb begin
    unique case (state_r)
      ST_INHERIT: begin
        // The owner inherits when the caller's priority is strictly above its own.
        cmp_req.cand_v    = 1'b1;
        cmp_req.cand_prio = best_prio_r;
        cmp_req.best_v    = 1'b1;
        cmp_req.best_prio = rd_eff;
      end
      ST_RAISE: begin
        cmp_req.cand_v    = best_v_r;
        cmp_req.cand_prio = best_prio_r;
        cmp_req.best_v    = 1'b1;
        cmp_req.best_prio = w_prio_r;
      end
      default: begin
        cmp_req.cand_v    = scan_cand_v;
        cmp_req.cand_prio = rd_eff;
        cmp_req.best_v    = best_v_r;
        cmp_req.best_prio = best_prio_r;
      end
    endcase
  end

  always_comb begin
    cur_v    = best_v_r;
    cur_idx  = best_idx_r;
    cur_prio = best_prio_r;
    if (take) begin
      cur_v    = 1'b1;
      cur_idx  = scan_idx_r;
      cur_prio = rd_eff;
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign tid_bad  = (32'(tid_r) >= 32'(NUM_TASKS)) || active_r[TASK_BITS'(tid_r)];

  // Next-state logic of the sequencer and of the scheduler state.
  always_comb begin
    state_nxt        = state_r;
    purpose_nxt      = purpose_r;
    scan_idx_nxt     = scan_idx_r;
    best_v_nxt       = best_v_r;
    best_idx_nxt     = best_idx_r;
    best_prio_nxt    = best_prio_r;
    w_prio_nxt       = w_prio_r;
    inh_en_nxt       = inh_en_r;
    active_nxt       = active_r;
    blocked_nxt      = blocked_r;
    held_nxt         = held_r;
    owner_nxt        = owner_r;
    time_nxt         = time_r;
    cmd_nxt          = cmd_r;
    tid_nxt          = tid_r;
    prio_nxt         = prio_r;
    status_nxt       = status_r;
    grant_v_nxt      = grant_v_r;
    grant_task_nxt   = grant_task_r;
    wait_nxt         = wait_r;
    out_valid_nxt    = out_valid_r;
    o_run_v_nxt      = o_run_v_r;
    o_run_task_nxt   = o_run_task_r;
    o_run_prio_nxt   = o_run_prio_r;
    o_grant_v_nxt    = o_grant_v_r;
    o_grant_task_nxt = o_grant_task_r;
    o_wait_nxt       = o_wait_r;
    o_status_nxt     = o_status_r;
    tbl_wr           = '0;
    rt_we            = 1'b0;
    rt_idx           = best_idx_r;
    scan_start       = 1'b0;
    scan_sel         = SP_POST;

    if (cfg_wr_en) begin
      inh_en_nxt = cfg_wr_data;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_command;
          tid_nxt        = in_task_id;
          prio_nxt       = PRIO_BITS'(in_base_priority);
          status_nxt     = STATUS_OK;
          grant_v_nxt    = 1'b0;
          grant_task_nxt = '0;
          wait_nxt       = '0;
          if ((in_command == CMD_LOCK) || (in_command == CMD_UNLOCK) ||
              (in_command == CMD_END)) begin
            scan_start = 1'b1;
            scan_sel   = SP_PRE;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end

      ST_SCAN: begin
        best_v_nxt    = cur_v;
        best_idx_nxt  = cur_idx;
        best_prio_nxt = cur_prio;
        if (scan_idx_r == LAST_IDX) begin
          unique case (purpose_r)
            SP_PRE:  state_nxt = ST_EXEC;
            SP_NEXT: state_nxt = ST_RAISE;
            SP_POST: state_nxt = ST_DONE;
            SP_WAITER: begin
              scan_start = 1'b1;
              if (!cur_v) begin
                held_nxt = 1'b0;
              end else begin
                // Hand the mutex to the best waiter and report how long it waited.
                blocked_nxt[cur_idx] = 1'b0;
                owner_nxt            = cur_idx;
                grant_v_nxt          = 1'b1;
                grant_task_nxt       = cur_idx;
                wait_nxt             = time_r - req_time_r[cur_idx];
                w_prio_nxt           = cur_prio;
                if (inh_en_r) begin
                  scan_sel = SP_NEXT;
                end
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end

      ST_EXEC: begin
        scan_start = 1'b1;
        if (cmd_r == CMD_TICK) begin
          time_nxt = time_r + 1'b1;
        end else if (cmd_r == CMD_RELEASE) begin
          if (tid_bad) begin
            status_nxt = STATUS_ACTIVE;
          end else begin
            active_nxt[TASK_BITS'(tid_r)]  = 1'b1;
            blocked_nxt[TASK_BITS'(tid_r)] = 1'b0;
            tbl_wr.we_base = 1'b1;
            tbl_wr.we_eff  = 1'b1;
            tbl_wr.idx     = TASK_BITS'(tid_r);
            tbl_wr.base    = prio_r;
            tbl_wr.eff     = prio_r;
          end
        end else if (cmd_r > CMD_END) begin
          status_nxt = STATUS_RULE;
        end else if (!best_v_r) begin
          status_nxt = STATUS_NO_RUNNING;
        end else if (cmd_r == CMD_LOCK) begin
          if (held_r && (owner_r == best_idx_r)) begin
            status_nxt = STATUS_RULE;
          end else if (!held_r) begin
            held_nxt       = 1'b1;
            owner_nxt      = best_idx_r;
            rt_we          = 1'b1;
            grant_v_nxt    = 1'b1;
            grant_task_nxt = best_idx_r;
            wait_nxt       = '0;
          end else begin
            blocked_nxt[best_idx_r] = 1'b1;
            rt_we                   = 1'b1;
            if (inh_en_r) begin
              scan_start = 1'b0;
              state_nxt  = ST_INHERIT;
            end
          end
        end else if (cmd_r == CMD_UNLOCK) begin
          if (!held_r || (owner_r != best_idx_r)) begin
            status_nxt = STATUS_RULE;
          end else begin
            scan_start = 1'b0;
            state_nxt  = ST_RESTORE;
          end
        end else begin
          if (held_r && (owner_r == best_idx_r)) begin
            status_nxt = STATUS_RULE;
          end else begin
            active_nxt[best_idx_r] = 1'b0;
            tbl_wr.we_base = 1'b1;
            tbl_wr.we_eff  = 1'b1;
            tbl_wr.idx     = best_idx_r;
            tbl_wr.base    = '0;
            tbl_wr.eff     = '0;
          end
        end
      end

      ST_INHERIT: begin
        if (take) begin
          tbl_wr.we_eff = 1'b1;
          tbl_wr.idx    = owner_r;
          tbl_wr.eff    = best_prio_r;
        end
        scan_start = 1'b1;
      end

      ST_RESTORE: begin
        // The releasing owner drops back to its base priority.
        tbl_wr.we_eff = 1'b1;
        tbl_wr.idx    = best_idx_r;
        tbl_wr.eff    = rd_base;
        scan_start    = 1'b1;
        scan_sel      = SP_WAITER;
      end

      ST_RAISE: begin
        if (take) begin
          tbl_wr.we_eff = 1'b1;
          tbl_wr.idx    = owner_r;
          tbl_wr.eff    = best_prio_r;
        end
        scan_start = 1'b1;
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          o_run_v_nxt      = best_v_r;
          o_run_task_nxt   = best_v_r ? 3'(best_idx_r) : 3'd0;
          o_run_prio_nxt   = best_v_r ? 4'(best_prio_r) : 4'd0;
          o_grant_v_nxt    = grant_v_r;
          o_grant_task_nxt = 3'(grant_task_r);
          o_wait_nxt       = 32'(wait_r);
          o_status_nxt     = status_r | {1'b0, status_ok_unused};
          state_nxt        = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (scan_start) begin
      state_nxt    = ST_SCAN;
      purpose_nxt  = scan_sel;
      scan_idx_nxt = '0;
      best_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      purpose_r   <= SP_POST;
      scan_idx_r  <= '0;
      best_v_r    <= 1'b0;
      inh_en_r    <= 1'b0;
      active_r    <= '0;
      blocked_r   <= '0;
      held_r      <= 1'b0;
      owner_r     <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      purpose_r      <= purpose_nxt;
      scan_idx_r     <= scan_idx_nxt;
      best_v_r       <= best_v_nxt;
      best_idx_r     <= best_idx_nxt;
      best_prio_r    <= best_prio_nxt;
      w_prio_r       <= w_prio_nxt;
      inh_en_r       <= inh_en_nxt;
      active_r       <= active_nxt;
      blocked_r      <= blocked_nxt;
      held_r         <= held_nxt;
      owner_r        <= owner_nxt;
      time_r         <= time_nxt;
      cmd_r          <= cmd_nxt;
      tid_r          <= tid_nxt;
      prio_r         <= prio_nxt;
      status_r       <= status_nxt;
      grant_v_r      <= grant_v_nxt;
      grant_task_r   <= grant_task_nxt;
      wait_r         <= wait_nxt;
      out_valid_r    <= out_valid_nxt;
      o_run_v_r      <= o_run_v_nxt;
      o_run_task_r   <= o_run_task_nxt;
      o_run_prio_r   <= o_run_prio_nxt;
      o_grant_v_r    <= o_grant_v_nxt;
      o_grant_task_r <= o_grant_task_nxt;
      o_wait_r       <= o_wait_nxt;
      o_status_r     <= o_status_nxt;
    end
  end

  // Lock request times are written when the running task asks for the mutex.
  always_ff @(posedge clk) begin
    if (rt_we) begin
      req_time_r[rt_idx] <= time_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_running_valid    = o_run_v_r;
  assign out_running_task     = o_run_task_r;
  assign out_running_priority = o_run_prio_r;
  assign out_grant_valid      = o_grant_v_r;
  assign out_granted_task     = o_grant_task_r;
  assign out_wait_time        = o_wait_r;
  assign out_status           = o_status_r;

  // Waiters are always tasks that are still active.
  a_blocked_active: assert property (@(posedge clk) disable iff (!rst_n)
    (blocked_r & ~active_r) == '0)
    else $error("blocked task is not active");

  // The mutex owner cannot end while it holds the mutex, so it stays active.
  a_owner_active: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> active_r[owner_r])
    else $error("mutex owner is not active");

  // Waiters exist only while the mutex is held.
  a_waiters_need_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (blocked_r != '0) |-> held_r)
    else $error("waiters present with the mutex free");

  // A grant is only ever reported for a request that completed without error.
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_grant_v_r) |-> (o_status_r == STATUS_OK))
    else $error("grant reported with an error status");

endmodule

@@ test/tb_priority_scheduler_with_inheritance.sv @@
// Self-checking testbench for the priority scheduler with one mutex and priority inheritance.
`timescale 1ns / 100ps

module tb_priority_scheduler_with_inheritance;
  import psi_pkg::*;

  // Command codes above CMD_END are illegal and must be flagged and ignored.
  localparam logic [2:0] CMD_BAD_LO = 3'd5;
  localparam logic [2:0] CMD_BAD_HI = 3'd7;

  // The receiver's long hold-off, the settling pause before a register write, the drain at
  // the end and the watchdog's limit on cycles in which no handshake completes. The limit
  // leaves a wide margin over the hold-off.
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 40;
  localparam int TAIL_CYCLES     = 64;
  localparam int QUIET_LIMIT     = 4000;
  localparam int PHASE_REQUESTS  = 370;

  // One scheduling outcome, laid out like the result channel.
  typedef struct packed {
    logic      run_v;
    task_idx_t run_task;
    prio_t     run_prio;
    logic      grant_v;
    task_idx_t grant_task;
    time_t     waited;
    logic [1:0] status;
  } outcome_t;

  // One row of the directed stimulus. Where typed is set, want holds an outcome that is
  // obvious by inspection; all other rows are checked against the scheduler model below.
  typedef struct {
    bit         inherit;
    logic [2:0] cmd;
    task_idx_t  tid;
    prio_t      prio;
    bit         typed;
    outcome_t   want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_command;
  logic [2:0]  in_task_id;
  logic [3:0]  in_base_priority;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_running_valid;
  logic [2:0]  out_running_task;
  logic [3:0]  out_running_priority;
  logic        out_grant_valid;
  logic [2:0]  out_granted_task;
  logic [31:0] out_wait_time;
  logic [1:0]  out_status;

  priority_scheduler_with_inheritance dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_task_id           (in_task_id),
    .in_base_priority     (in_base_priority),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_running_valid    (out_running_valid),
    .out_running_task     (out_running_task),
    .out_running_priority (out_running_priority),
    .out_grant_valid      (out_grant_valid),
    .out_granted_task     (out_granted_task),
    .out_wait_time        (out_wait_time),
    .out_status           (out_status)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Scheduler model: its own copy of the task table, the mutex and the clock.
  // ---------------------------------------------------------------------------------------
  prio_t      sched_base [NUM_TASKS];
  prio_t      sched_eff  [NUM_TASKS];
  time_t      lock_stamp [NUM_TASKS];
  task_mask_t sched_active;
  task_mask_t sched_blocked;
  logic       mutex_busy;
  task_idx_t  mutex_holder;
  time_t      sched_clock;
  bit         sched_inherit;

  // Outcomes of accepted requests, oldest first, waiting for the result channel.
  outcome_t   scheduler_outcomes[$];
  stim_row_t  stim_rows[$];

  int error_count = 0;
  int burst_left = 0;
  int hold_requests = 0;
  int hold_served = 0;

  // Highest effective priority within a mask, lowest index on a tie; -1 for an empty mask.
  function automatic int pick_best(input task_mask_t m);
    int best;
    int i;
    best = -1;
    for (i = 0; i < NUM_TASKS; i++) begin
      if (m[i] && (best < 0 || sched_eff[i] > sched_eff[best])) begin
        best = i;
      end
    end
    return best;
  endfunction

  function automatic int running_now();
    return pick_best(sched_active & ~sched_blocked);
  endfunction

  // Applies one command to the model and returns what the block should report for it.
  function automatic outcome_t schedule_step(input logic [2:0] cmd, input task_idx_t tid,
                                             input prio_t prio);
    outcome_t o;
    int r;
    int w;
    int nxt;
    o = '0;
    o.status = STATUS_OK;
    r = running_now();
    if (cmd == CMD_TICK) begin
      sched_clock = sched_clock + 1'b1;
    end else if (cmd == CMD_RELEASE) begin
      if (sched_active[tid]) begin
        o.status = STATUS_ACTIVE;
      end else begin
        sched_active[tid]  = 1'b1;
        sched_blocked[tid] = 1'b0;
        sched_base[tid]    = prio;
        sched_eff[tid]     = prio;
      end
    end else if (cmd > CMD_END) begin
      o.status = STATUS_RULE;
    end else if (r < 0) begin
      o.status = STATUS_NO_RUNNING;
    end else if (cmd == CMD_LOCK) begin
      if (mutex_busy && mutex_holder == r) begin
        o.status = STATUS_RULE;
      end else if (!mutex_busy) begin
        mutex_busy    = 1'b1;
        mutex_holder  = TASK_BITS'(r);
        lock_stamp[r] = sched_clock;
        o.grant_v     = 1'b1;
        o.grant_task  = TASK_BITS'(r);
      end else begin
        // The caller waits; with inheritance on, the holder is lifted to its priority.
        sched_blocked[r] = 1'b1;
        lock_stamp[r]    = sched_clock;
        if (sched_inherit && sched_eff[mutex_holder] < sched_eff[r]) begin
          sched_eff[mutex_holder] = sched_eff[r];
        end
      end
    end else if (cmd == CMD_UNLOCK) begin
      if (!mutex_busy || mutex_holder != r) begin
        o.status = STATUS_RULE;
      end else begin
        sched_eff[r] = sched_base[r];
        w = pick_best(sched_blocked);
        if (w < 0) begin
          mutex_busy = 1'b0;
        end else begin
          // Handover to the best waiter, which may inherit from those still waiting.
          sched_blocked[w] = 1'b0;
          mutex_holder     = TASK_BITS'(w);
          o.grant_v        = 1'b1;
          o.grant_task     = TASK_BITS'(w);
          o.waited         = sched_clock - lock_stamp[w];
          nxt = pick_best(sched_blocked);
          if (sched_inherit && nxt >= 0 && sched_eff[w] < sched_eff[nxt]) begin
            sched_eff[w] = sched_eff[nxt];
          end
        end
      end
    end else begin
      if (mutex_busy && mutex_holder == r) begin
        o.status = STATUS_RULE;
      end else begin
        sched_active[r] = 1'b0;
        sched_base[r]   = '0;
        sched_eff[r]    = '0;
      end
    end
    r = running_now();
    if (r >= 0) begin
      o.run_v    = 1'b1;
      o.run_task = TASK_BITS'(r);
      o.run_prio = sched_eff[r];
    end
    return o;
  endfunction

  function automatic outcome_t outcome_of(input bit rv, input task_idx_t rt, input prio_t rp,
                                          input bit gv, input task_idx_t gt, input time_t wt,
                                          input logic [1:0] st);
    outcome_t o;
    o.run_v      = rv;
    o.run_task   = rt;
    o.run_prio   = rp;
    o.grant_v    = gv;
    o.grant_task = gt;
    o.waited     = wt;
    o.status     = st;
    return o;
  endfunction

  function automatic void add_row(input bit inh, input logic [2:0] cmd, input task_idx_t tid,
                                  input prio_t prio);
    stim_row_t row;
    row.inherit = inh;
    row.cmd     = cmd;
    row.tid     = tid;
    row.prio    = prio;
    row.typed   = 1'b0;
    row.want    = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_typed(input bit inh, input logic [2:0] cmd, input task_idx_t tid,
                                    input prio_t prio, input outcome_t want);
    stim_row_t row;
    row.inherit = inh;
    row.cmd     = cmd;
    row.tid     = tid;
    row.prio    = prio;
    row.typed   = 1'b1;
    row.want    = want;
    stim_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Checking. Every mismatch goes through one task, which prints a line and counts it.
  // ---------------------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // Outputs are sampled at the rising edge, before the block's own updates of that edge.
  always @(posedge clk) begin : result_checker
    outcome_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (scheduler_outcomes.size() == 0) begin
        report_mismatch("result with no request outstanding", 32'd0, 32'd0);
      end else begin
        want = scheduler_outcomes.pop_front();
        check_field("running_valid", 32'(out_running_valid), 32'(want.run_v));
        check_field("running_task", 32'(out_running_task), 32'(want.run_task));
        check_field("running_priority", 32'(out_running_priority), 32'(want.run_prio));
        check_field("grant_valid", 32'(out_grant_valid), 32'(want.grant_v));
        check_field("granted_task", 32'(out_granted_task), 32'(want.grant_task));
        check_field("wait_time", out_wait_time, want.waited);
        check_field("status", 32'(out_status), 32'(want.status));
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Watchdog: ends the run if no handshake on either channel completes for too long.
  // ---------------------------------------------------------------------------------------
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
    $display("** priority_scheduler_with_inheritance: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Receiver. It runs through stall patterns of its own, in turn: no stall,
  // coin flips, a fixed three-in-seven rhythm, and heavy stalling. When the stimulus asks,
  // it holds off for a long stretch, counted here, so that the block fills up and stalls
  // its request channel while the sender keeps offering.
  // ---------------------------------------------------------------------------------------
  always begin : receiver_pattern
    int stall_cycle;
    @(negedge clk);
    stall_cycle++;
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      out_stall = 1'b1;
      repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
    end else begin
      case ((stall_cycle / 97) % 4)
        0: begin
          out_stall = 1'b0;
        end
        1: begin
          out_stall = ($urandom_range(0, 1) == 0);
        end
        2: begin
          out_stall = ((stall_cycle % 7) < 3);
        end
        default: begin
          out_stall = ($urandom_range(0, 9) < 8);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------
  // Sender. Requests go out in bursts of random length, with random gaps between bursts.
  // Inputs change only at the falling edge; a request is accepted at the rising edge at
  // which in_stall is low, and the model is advanced there.
  // ---------------------------------------------------------------------------------------
  task automatic send_request(input logic [2:0] cmd, input task_idx_t tid, input prio_t prio,
                              input bit typed, input outcome_t want);
    int gap;
    outcome_t predicted;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid         = 1'b1;
    in_command       = cmd;
    in_task_id       = tid;
    in_base_priority = prio;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    predicted = schedule_step(cmd, tid, prio);
    scheduler_outcomes.push_back(typed ? want : predicted);
  endtask

  // Drops the request valid and waits until every outstanding result has been seen.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (scheduler_outcomes.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // The register is written only with the block idle; every request yields one result,
  // but a short pause past the longest latency is allowed before the write anyway.
  task automatic write_inheritance(input bit value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    sched_inherit = value;
  endtask

  // ---------------------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    int n;
    int roll;
    int i;
    logic [2:0] cmd;
    task_idx_t  tid;
    prio_t      prio;

    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = 1'b0;
    in_valid         = 1'b0;
    in_command       = CMD_TICK;
    in_task_id       = '0;
    in_base_priority = '0;

    // Model state after reset: nothing released, mutex free, clock at zero.
    for (i = 0; i < NUM_TASKS; i++) begin
      sched_base[i] = '0;
      sched_eff[i]  = '0;
      lock_stamp[i] = '0;
    end
    sched_active  = '0;
    sched_blocked = '0;
    mutex_busy    = 1'b0;
    mutex_holder  = '0;
    sched_clock   = '0;
    sched_inherit = 1'b0;

    // Directed part without inheritance. With no task released, lock, unlock and end find
    // no running task, and unknown commands are flagged.
    add_typed(0, CMD_TICK, 0, 0, outcome_of(0, 0, 0, 0, 0, 0, STATUS_OK));
    add_typed(0, CMD_LOCK, 0, 0, outcome_of(0, 0, 0, 0, 0, 0, STATUS_NO_RUNNING));
    add_typed(0, CMD_UNLOCK, 7, 15, outcome_of(0, 0, 0, 0, 0, 0, STATUS_NO_RUNNING));
    add_typed(0, CMD_END, 0, 0, outcome_of(0, 0, 0, 0, 0, 0, STATUS_NO_RUNNING));
    add_typed(0, CMD_BAD_LO, 7, 15, outcome_of(0, 0, 0, 0, 0, 0, STATUS_RULE));
    add_typed(0, CMD_BAD_HI, 0, 0, outcome_of(0, 0, 0, 0, 0, 0, STATUS_RULE));
    // Lowest priority on the lowest task, then a second release of the same task.
    add_typed(0, CMD_RELEASE, 0, 0, outcome_of(1, 0, 0, 0, 0, 0, STATUS_OK));
    add_typed(0, CMD_RELEASE, 0, 15, outcome_of(1, 0, 0, 0, 0, 0, STATUS_ACTIVE));
    // Highest priority on the highest task; it takes the free mutex at once.
    add_typed(0, CMD_RELEASE, 7, 15, outcome_of(1, 7, 15, 0, 0, 0, STATUS_OK));
    add_typed(0, CMD_LOCK, 0, 0, outcome_of(1, 7, 15, 1, 7, 0, STATUS_OK));
    // The holder locking again, and trying to end while it holds the mutex.
    add_typed(0, CMD_LOCK, 0, 0, outcome_of(1, 7, 15, 0, 0, 0, STATUS_RULE));
    add_typed(0, CMD_END, 0, 0, outcome_of(1, 7, 15, 0, 0, 0, STATUS_RULE));
    // A priority tie goes to the lower index; that task then blocks on the held mutex,
    // waits two ticks and is handed the mutex on unlock.
    add_row(0, CMD_RELEASE, 3, 15);
    add_row(0, CMD_LOCK, 0, 0);
    add_row(0, CMD_TICK, 0, 0);
    add_row(0, CMD_TICK, 0, 0);
    add_row(0, CMD_UNLOCK, 0, 0);
    add_row(0, CMD_UNLOCK, 0, 0);
    // Unlock with the mutex free, then ending the running task.
    add_row(0, CMD_UNLOCK, 0, 0);
    add_row(0, CMD_END, 0, 0);
    // Directed part with inheritance: the top task ends first, then a low holder is lifted
    // by two waiters in turn, an unlock by a task that does not hold the mutex is refused,
    // and the handover leaves a waiter behind.
    add_row(1, CMD_END, 0, 0);
    add_row(1, CMD_RELEASE, 1, 1);
    add_row(1, CMD_LOCK, 0, 0);
    add_row(1, CMD_RELEASE, 4, 12);
    add_row(1, CMD_LOCK, 0, 0);
    add_row(1, CMD_RELEASE, 6, 14);
    add_row(1, CMD_LOCK, 0, 0);
    add_row(1, CMD_TICK, 0, 0);
    add_row(1, CMD_RELEASE, 2, 15);
    add_row(1, CMD_UNLOCK, 0, 0);
    add_row(1, CMD_END, 0, 0);
    add_row(1, CMD_UNLOCK, 0, 0);
    add_row(1, CMD_UNLOCK, 0, 0);

    // Reset is released once and never asserted again.
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].inherit != sched_inherit) begin
        write_inheritance(stim_rows[i].inherit);
      end
      send_request(stim_rows[i].cmd, stim_rows[i].tid, stim_rows[i].prio,
                   stim_rows[i].typed, stim_rows[i].want);
    end

    // Random part, in phases that alternate the inheritance setting. Most requests are
    // ones the scheduler acts on: releases mostly pick a task that is not yet active, and
    // locks, unlocks and ends come from whichever task is running. The rest is noise:
    // releases of active tasks, unlocks by non-holders and unknown commands.
    for (phase = 0; phase < 4; phase++) begin
      write_inheritance(1'(phase % 2));
      for (n = 0; n < PHASE_REQUESTS; n++) begin
        if (phase == 1 && n == 100) begin
          // Ask the receiver for its long hold-off; the sender carries on regardless.
          hold_requests++;
        end
        if (phase == 2 && n == 200) begin
          // The sender pauses until every outstanding request has produced its result.
          drain_results();
        end
        roll = $urandom_range(0, 99);
        tid  = TASK_BITS'($urandom_range(0, NUM_TASKS - 1));
        prio = PRIO_BITS'($urandom_range(0, (1 << PRIO_BITS) - 1));
        if (roll < 22) begin
          cmd = CMD_TICK;
        end else if (roll < 46) begin
          cmd = CMD_RELEASE;
          if ($urandom_range(0, 3) != 0 && sched_active != '1) begin
            do begin
              tid = TASK_BITS'($urandom_range(0, NUM_TASKS - 1));
            end while (sched_active[tid]);
          end
        end else if (roll < 62) begin
          cmd = CMD_LOCK;
        end else if (roll < 78) begin
          cmd = CMD_UNLOCK;
        end else if (roll < 92) begin
          cmd = CMD_END;
        end else begin
          cmd = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
        end
        send_request(cmd, tid, prio, 1'b0, '0);
      end
    end

    // Every result must arrive, then a quiet tail catches any stray extra result.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** priority_scheduler_with_inheritance: PASSED **");
    end else begin
      $display("** priority_scheduler_with_inheritance: FAILED **");
    end
    $finish;
  end

endmodule

@@ priority_scheduler_with_inheritance.f @@
rtl/psi_pkg.sv
rtl/psi_cmp.sv
rtl/psi_task_tbl.sv
rtl/priority_scheduler_with_inheritance.sv
test/tb_priority_scheduler_with_inheritance.sv
